// File: rtl/lsc_pkg.sv
package lsc_pkg;

  localparam int DEF_COORD_BITS      = 10;
  localparam int DEF_SLOPE_FRAC_BITS = 12;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PULSE_W     = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_GAIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE_SETPOINT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_ROW      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CORNER_ROW     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_WEIGHT  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEER_LIMIT    = 3'd7;

  localparam logic [10:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [11:0] RST_SLOPE_GAIN     = 12'd1000;
  localparam logic [7:0]  RST_OFFSET_GAIN    = 8'd3;
  localparam logic [14:0] RST_SLOPE_SETPOINT = 15'd1638;
  localparam logic [9:0]  RST_ENTRY_ROW      = 10'd300;
  localparam logic [9:0]  RST_CORNER_ROW     = 10'd340;
  localparam logic [15:0] RST_FILTER_WEIGHT  = 16'd10923;
  localparam logic [8:0]  RST_STEER_LIMIT    = 9'd400;

  localparam logic [PULSE_W-1:0] STEER_CENTER   = 11'd1500;
  localparam logic [PULSE_W-1:0] THROTTLE_FIXED = 11'd1450;

  typedef struct packed {
    logic [10:0] image_width;
    logic [11:0] slope_gain;
    logic [7:0]  offset_gain;
    logic [14:0] slope_setpoint;
    logic [9:0]  entry_row;
    logic [9:0]  corner_row;
    logic [15:0] filter_weight;
    logic [8:0]  steer_limit;
  } cfg_t;

endpackage

// File: rtl/lane_steering_controller_top.sv
// Lane steering controller. Segments are pushed as words into a two-word
// queue; each word passes through the one-bit-per-cycle divider that
// computes the left and then the right slope, followed by twelve steps
// through one shared multiplier for the line rows, control law and low-pass
// filter. One result word waits in an output register until popped.
// Configuration writes take effect at once; the user must keep them to
// idle periods only, as the block itself does not enforce this.
module lane_steering_controller_top #(
  parameter int COORD_BITS      = lsc_pkg::DEF_COORD_BITS,
  parameter int SLOPE_FRAC_BITS = lsc_pkg::DEF_SLOPE_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [COORD_BITS-1:0]           left_ax,
  input  logic [COORD_BITS-1:0]           left_ay,
  input  logic [COORD_BITS-1:0]           left_bx,
  input  logic [COORD_BITS-1:0]           left_by,
  input  logic [COORD_BITS-1:0]           right_ax,
  input  logic [COORD_BITS-1:0]           right_ay,
  input  logic [COORD_BITS-1:0]           right_bx,
  input  logic [COORD_BITS-1:0]           right_by,
  output logic                            empty,
  input  logic                            pop,
  output logic [lsc_pkg::PULSE_W-1:0]     steer_pulse,
  output logic [lsc_pkg::PULSE_W-1:0]     throttle_pulse,
  output logic                            turning,
  output logic                            corner_forced,
  input  logic                            cfg_we,
  input  logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int EW = 8 * COORD_BITS + 4;

  lsc_pkg::cfg_t   cfg;
  logic [EW-1:0]   entry, q_data;
  logic            q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= lsc_pkg::RST_IMAGE_WIDTH;
      cfg.slope_gain     <= lsc_pkg::RST_SLOPE_GAIN;
      cfg.offset_gain    <= lsc_pkg::RST_OFFSET_GAIN;
      cfg.slope_setpoint <= lsc_pkg::RST_SLOPE_SETPOINT;
      cfg.entry_row      <= lsc_pkg::RST_ENTRY_ROW;
      cfg.corner_row     <= lsc_pkg::RST_CORNER_ROW;
      cfg.filter_weight  <= lsc_pkg::RST_FILTER_WEIGHT;
      cfg.steer_limit    <= lsc_pkg::RST_STEER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        lsc_pkg::CFG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data[10:0];
        lsc_pkg::CFG_SLOPE_GAIN:     cfg.slope_gain     <= cfg_data[11:0];
        lsc_pkg::CFG_OFFSET_GAIN:    cfg.offset_gain    <= cfg_data[7:0];
        lsc_pkg::CFG_SLOPE_SETPOINT: cfg.slope_setpoint <= cfg_data[14:0];
        lsc_pkg::CFG_ENTRY_ROW:      cfg.entry_row      <= cfg_data[9:0];
        lsc_pkg::CFG_CORNER_ROW:     cfg.corner_row     <= cfg_data[9:0];
        lsc_pkg::CFG_FILTER_WEIGHT:  cfg.filter_weight  <= cfg_data[15:0];
        lsc_pkg::CFG_STEER_LIMIT:    cfg.steer_limit    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  lsc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .left_ax (left_ax),
    .left_ay (left_ay),
    .left_bx (left_bx),
    .left_by (left_by),
    .right_ax(right_ax),
    .right_ay(right_ay),
    .right_bx(right_bx),
    .right_by(right_by),
    .entry   (entry)
  );

  lsc_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata(entry),
    .rd   (q_pop),
    .rdata(q_data),
    .full (full),
    .empty(q_empty)
  );

  lsc_back #(
    .COORD_BITS     (COORD_BITS),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .steer_pulse  (steer_pulse),
    .turning      (turning),
    .corner_forced(corner_forced)
  );

  assign throttle_pulse = lsc_pkg::THROTTLE_FIXED;

  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  assert property (@(posedge clk) disable iff (rst) full |-> !q_empty)
    else $error("full queue reports empty");

  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (steer_pulse >= 11'd989 && steer_pulse <= 11'd2011))
    else $error("steer pulse out of range");

endmodule

// File: rtl/lsc_front.sv
module lsc_front #(
  parameter int COORD_BITS = lsc_pkg::DEF_COORD_BITS
) (
  input  logic [COORD_BITS-1:0]   left_ax,
  input  logic [COORD_BITS-1:0]   left_ay,
  input  logic [COORD_BITS-1:0]   left_bx,
  input  logic [COORD_BITS-1:0]   left_by,
  input  logic [COORD_BITS-1:0]   right_ax,
  input  logic [COORD_BITS-1:0]   right_ay,
  input  logic [COORD_BITS-1:0]   right_bx,
  input  logic [COORD_BITS-1:0]   right_by,
  output logic [8*COORD_BITS+3:0] entry
);

  localparam int C = COORD_BITS;

  logic [C:0]   ldx, ldy, rdx, rdy;
  logic [C-1:0] ldxa, ldya, rdxa, rdya;
  logic         lneg, rneg, lvert, rvert;

  always_comb begin
    ldx   = {1'b0, left_ax} - {1'b0, left_bx};
    ldy   = {1'b0, left_ay} - {1'b0, left_by};
    rdx   = {1'b0, right_ax} - {1'b0, right_bx};
    rdy   = {1'b0, right_ay} - {1'b0, right_by};
    ldxa  = ldx[C] ? C'(-ldx) : ldx[C-1:0];
    ldya  = ldy[C] ? C'(-ldy) : ldy[C-1:0];
    rdxa  = rdx[C] ? C'(-rdx) : rdx[C-1:0];
    rdya  = rdy[C] ? C'(-rdy) : rdy[C-1:0];
    lneg  = ldx[C] ^ ldy[C];
    rneg  = rdx[C] ^ rdy[C];
    lvert = (ldx == '0);
    rvert = (rdx == '0);
    entry = {right_ay, right_ax, rvert, rneg, rdxa, rdya,
             left_ay, left_ax, lvert, lneg, ldxa, ldya};
  end

endmodule

// File: rtl/lsc_fifo.sv
module lsc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

// File: rtl/lsc_back.sv
module lsc_back #(
  parameter int COORD_BITS      = lsc_pkg::DEF_COORD_BITS,
  parameter int SLOPE_FRAC_BITS = lsc_pkg::DEF_SLOPE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lsc_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  logic [8*COORD_BITS+3:0]     q_data,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [lsc_pkg::PULSE_W-1:0] steer_pulse,
  output logic                        turning,
  output logic                        corner_forced
);

  localparam int C    = COORD_BITS;
  localparam int F    = SLOPE_FRAC_BITS;
  localparam int N    = C + F;
  localparam int SW   = F + 4;
  localparam int DW   = ((C > 11) ? C : 11) + 1;
  localparam int YW   = SW + DW + 1;
  localparam int EW   = ((SW > 16) ? SW : 16) + 1;
  localparam int RW   = YW + 1;
  localparam int MA   = (SW > 18) ? SW : 18;
  localparam int MB   = (RW > EW) ? RW : EW;
  localparam int PW   = MA + MB;
  localparam int AW   = PW + 1;
  localparam int CW   = $clog2(N + 1);
  localparam int SIDE = 4 * C + 2;

  localparam logic [N-1:0]  SMAX   = N'((1 << (F + 3)) - 1);
  localparam logic [CW-1:0] LAST   = CW'(N - 1);
  localparam logic signed [AW-1:0] RND_F  = AW'((1 << F) - 1);
  localparam logic signed [AW-1:0] RND_16 = AW'(65535);
  localparam logic signed [AW-1:0] CMD_HI = AW'(32767);
  localparam logic signed [AW-1:0] CMD_LO = -AW'(32767);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_P0   = 4'd2;
  localparam logic [3:0] S_P1   = 4'd3;
  localparam logic [3:0] S_P2   = 4'd4;
  localparam logic [3:0] S_P3   = 4'd5;
  localparam logic [3:0] S_P4   = 4'd6;
  localparam logic [3:0] S_P5   = 4'd7;
  localparam logic [3:0] S_P6   = 4'd8;
  localparam logic [3:0] S_P7   = 4'd9;
  localparam logic [3:0] S_P8   = 4'd10;
  localparam logic [3:0] S_P9   = 4'd11;
  localparam logic [3:0] S_P10  = 4'd12;
  localparam logic [3:0] S_P11  = 4'd13;

  logic [3:0]            state;
  logic [8*C+3:0]        item;
  logic                  side;
  logic [N-1:0]          num;
  logic [C-1:0]          rem;
  logic [C-1:0]          den;
  logic [CW-1:0]         cnt;
  logic signed [SW-1:0]  al, ar;
  logic signed [YW-1:0]  yl, yr;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  acc_r, acc_l, accf;
  logic signed [15:0]    cmd;
  logic signed [15:0]    cur;
  logic signed [15:0]    filter_value;
  logic                  turn_mode;
  logic                  out_valid;

  logic [SIDE-1:0]       lside, rside;
  logic [C-1:0]          l_ax, l_ay, r_dya, r_dxa, r_ax, r_ay;
  logic                  l_neg, l_vert, r_neg, r_vert;
  logic [C:0]            r2;
  logic                  ge;
  logic [N-1:0]          qfin, qsat;
  logic                  sneg, svert;
  logic signed [SW-1:0]  slope_next;
  logic signed [MA-1:0]  ma;
  logic signed [MB-1:0]  mb;
  logic signed [YW-1:0]  ys, yt;
  logic signed [EW-1:0]  e_r, e_l;
  logic signed [RW-1:0]  d_r, d_l;
  logic signed [AW-1:0]  t_r, t_l, law_r, law_l, fs, ft;
  logic                  tm_next;
  logic signed [15:0]    cmd_next;
  logic signed [16:0]    lim, c17, val;
  logic                  forced;
  logic [16:0]           pulse;

  always_comb begin
    lside  = item[SIDE-1:0];
    rside  = item[2*SIDE-1:SIDE];
    l_neg  = lside[2*C];
    l_vert = lside[2*C+1];
    l_ax   = lside[3*C+1:2*C+2];
    l_ay   = lside[4*C+1:3*C+2];
    r_dya  = rside[C-1:0];
    r_dxa  = rside[2*C-1:C];
    r_neg  = rside[2*C];
    r_vert = rside[2*C+1];
    r_ax   = rside[3*C+1:2*C+2];
    r_ay   = rside[4*C+1:3*C+2];
  end

  always_comb begin
    r2    = {rem, num[N-1]};
    ge    = (r2 >= {1'b0, den});
    qfin  = {num[N-2:0], ge};
    qsat  = (qfin > SMAX) ? SMAX : qfin;
    sneg  = side ? r_neg : l_neg;
    svert = side ? r_vert : l_vert;
    if (svert) begin
      slope_next = '0;
    end else if (sneg) begin
      slope_next = -$signed(SW'(qsat));
    end else begin
      slope_next = $signed(SW'(qsat));
    end
  end

  always_comb begin
    ys  = YW'($signed({1'b0, cfg.entry_row, {F{1'b0}}}));
    yt  = YW'($signed({1'b0, cfg.corner_row, {F{1'b0}}}));
    e_r = EW'(ar) - EW'($signed({1'b0, cfg.slope_setpoint}));
    e_l = EW'(al) + EW'($signed({1'b0, cfg.slope_setpoint}));
    d_r = RW'(ys) - RW'(yr);
    d_l = RW'(yl) - RW'(ys);
    if (e_r > 0) e_r = '0;
    if (e_l < 0) e_l = '0;
    if (d_r > 0) d_r = '0;
    if (d_l < 0) d_l = '0;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_P0: begin
        ma = MA'(ar);
        mb = MB'($signed({1'b0, cfg.image_width})) - MB'($signed({1'b0, r_ax}));
      end
      S_P1: begin
        ma = MA'(al);
        mb = MB'($signed({1'b0, l_ax}));
      end
      S_P2: begin
        ma = MA'($signed({1'b0, cfg.slope_gain}));
        mb = MB'(e_r);
      end
      S_P3: begin
        ma = MA'($signed({1'b0, cfg.offset_gain}));
        mb = MB'(d_r);
      end
      S_P4: begin
        ma = MA'($signed({1'b0, cfg.slope_gain}));
        mb = MB'(e_l);
      end
      S_P5: begin
        ma = MA'($signed({1'b0, cfg.offset_gain}));
        mb = MB'(d_l);
      end
      S_P8: begin
        ma = MA'($signed({1'b0, cfg.filter_weight}));
        mb = MB'(filter_value);
      end
      S_P9: begin
        ma = MA'($signed(18'h10000 - {2'b0, cfg.filter_weight}));
        mb = MB'(cmd);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    t_r   = (acc_r < 0) ? (acc_r + RND_F) >>> F : acc_r >>> F;
    t_l   = (acc_l < 0) ? (acc_l + RND_F) >>> F : acc_l >>> F;
    law_r = (t_r > CMD_HI) ? CMD_HI : ((t_r < CMD_LO) ? CMD_LO : t_r);
    law_l = (t_l > CMD_HI) ? CMD_HI : ((t_l < CMD_LO) ? CMD_LO : t_l);
    tm_next  = turn_mode || (ys < yl) || (ys < yr);
    cmd_next = '0;
    if (tm_next) begin
      if (ar > 0 && al < 0) begin
        if (ys < yr) begin
          cmd_next = 16'(law_r);
        end else if (ys < yl) begin
          cmd_next = 16'(law_l);
        end else begin
          tm_next = 1'b0;
        end
      end else if (ar == al && ar > 0) begin
        if (ys < yr) begin
          cmd_next = 16'(law_r);
        end else begin
          tm_next = 1'b0;
        end
      end else if (ar == al && al < 0) begin
        if (ys < yl) begin
          cmd_next = 16'(law_l);
        end else begin
          tm_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    fs     = accf + AW'(prod);
    ft     = (fs < 0) ? (fs + RND_16) >>> 16 : fs >>> 16;
    lim    = $signed({8'b0, cfg.steer_limit});
    c17    = 17'(cur);
    val    = (c17 > lim) ? lim : ((c17 < -lim) ? -lim : c17);
    forced = 1'b0;
    if (yt < yl) begin
      val    = lim;
      forced = 1'b1;
    end
    if (yt < yr) begin
      val    = -lim;
      forced = 1'b1;
    end
    pulse = 17'({6'b0, lsc_pkg::STEER_CENTER}) + val;
  end

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      S_IDLE: begin
        item <= q_data;
        num  <= {q_data[C-1:0], {F{1'b0}}};
        den  <= q_data[2*C-1:C];
        rem  <= '0;
        cnt  <= '0;
        side <= 1'b0;
      end
      S_DIV: begin
        rem <= ge ? C'(r2 - {1'b0, den}) : r2[C-1:0];
        num <= qfin;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          if (side) begin
            ar <= slope_next;
          end else begin
            al   <= slope_next;
            side <= 1'b1;
            num  <= {r_dya, {F{1'b0}}};
            den  <= r_dxa;
            rem  <= '0;
            cnt  <= '0;
          end
        end
      end
      S_P1: yr <= YW'($signed({1'b0, r_ay, {F{1'b0}}})) + YW'(prod);
      S_P2: yl <= YW'($signed({1'b0, l_ay, {F{1'b0}}})) - YW'(prod);
      S_P3: acc_r <= AW'(prod);
      S_P4: acc_r <= acc_r + AW'(prod);
      S_P5: acc_l <= AW'(prod);
      S_P6: acc_l <= acc_l + AW'(prod);
      S_P7: cmd <= cmd_next;
      S_P9: accf <= AW'(prod);
      S_P10: cur <= 16'(ft);
      S_P11: begin
        if (!out_valid || pop) begin
          steer_pulse   <= pulse[lsc_pkg::PULSE_W-1:0];
          corner_forced <= forced;
          turning       <= turn_mode;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      turn_mode    <= 1'b0;
      filter_value <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == LAST && side) begin
            state <= S_P0;
          end
        end
        S_P7: begin
          turn_mode <= tm_next;
          state     <= S_P8;
        end
        S_P10: begin
          filter_value <= 16'(ft);
          state        <= S_P11;
        end
        S_P11: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= state + 4'd1;
      endcase
    end
  end

endmodule
